>>> sv/u8s_pkg.sv
package u8s_pkg;

   // most words one input byte can release
   localparam int unsigned GROUP_MAX = 4;
   // groups buffered between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] REPL_CHAR = 8'h3F;

   // words released by one input byte, data[0] goes out first
   typedef struct packed {
      logic [2:0]                  len;
      logic [GROUP_MAX-1:0][7:0]   data;
   } group_type;

   typedef struct packed {
      logic [1:0] held_count;
      logic [7:0] held_lead;
   } front_stat_type;

   typedef struct packed {
      logic [QUEUE_AW:0] level;
   } queue_stat_type;

   // total sequence length opened by a lead byte, zero if none
   function automatic logic [2:0] seq_len(input logic [7:0] b);
      logic [2:0] len;
      begin
         if ((b & 8'hE0) == 8'hC0) begin
            len = 3'd2;
         end else if ((b & 8'hF0) == 8'hE0) begin
            len = 3'd3;
         end else if ((b & 8'hF8) == 8'hF0) begin
            len = 3'd4;
         end else begin
            len = 3'd0;
         end
         return len;
      end
   endfunction

endpackage

>>> sv/u8s_front.sv
module u8s_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [7:0]               in_byte,
   input  logic                     in_end,
   output logic                     grp_valid,
   input  logic                     grp_ready,
   output u8s_pkg::group_type       grp,
   output u8s_pkg::front_stat_type  stat
);
   import u8s_pkg::*;

   logic [1:0] held_count_ff, held_count_in;
   logic [7:0] held_lead_ff, held_lead_in;
   logic [7:0] cont0_ff, cont0_in;
   logic [7:0] cont1_ff, cont1_in;

   logic       accept;
   logic       is_cont;
   logic       consumed;
   logic [2:0] need;
   logic [2:0] n;
   group_type  grp_c;

   assign accept = in_valid && in_ready;
   assign is_cont = (in_byte[7:6] == 2'b10);

   always_comb begin
      held_count_in = held_count_ff;
      held_lead_in  = held_lead_ff;
      cont0_in      = cont0_ff;
      cont1_in      = cont1_ff;
      consumed      = 1'b0;
      need          = seq_len(held_lead_ff);
      n             = 3'd0;
      grp_c.data    = '0;

      // bytes already held: extend, complete or break the sequence
      if (held_count_ff != 2'd0) begin
         if (is_cont) begin
            consumed = 1'b1;
            if (({1'b0, held_count_ff} + 3'd1) >= need) begin
               grp_c.data[0] = held_lead_ff;
               if (held_count_ff >= 2'd2) begin
                  grp_c.data[1] = cont0_ff;
               end
               if (held_count_ff == 2'd3) begin
                  grp_c.data[2] = cont1_ff;
               end
               grp_c.data[held_count_ff] = in_byte;
               n = {1'b0, held_count_ff} + 3'd1;
               held_count_in = 2'd0;
            end else begin
               if (held_count_ff == 2'd1) begin
                  cont0_in = in_byte;
               end else begin
                  cont1_in = in_byte;
               end
               held_count_in = held_count_ff + 2'd1;
            end
         end else begin
            for (int k = 0; k < 3; k++) begin
               if (2'(k) < held_count_ff) begin
                  grp_c.data[k] = REPL_CHAR;
               end
            end
            n = {1'b0, held_count_ff};
            held_count_in = 2'd0;
         end
      end

      // fresh byte
      if (!consumed && (in_byte != 8'h00)) begin
         if (!in_byte[7]) begin
            grp_c.data[n[1:0]] = in_byte;
            n = n + 3'd1;
         end else if (seq_len(in_byte) != 3'd0) begin
            held_lead_in  = in_byte;
            held_count_in = 2'd1;
         end else begin
            grp_c.data[n[1:0]] = REPL_CHAR;
            n = n + 3'd1;
         end
      end

      // end of string flushes whatever is still held
      if (in_end) begin
         for (int k = 0; k < GROUP_MAX; k++) begin
            if ((3'(k) >= n) && (3'(k) < (n + {1'b0, held_count_in}))) begin
               grp_c.data[k] = REPL_CHAR;
            end
         end
         n = n + {1'b0, held_count_in};
         held_count_in = 2'd0;
      end

      grp_c.len = n;
   end

   assign in_ready  = grp_ready;
   assign grp_valid = accept && (grp_c.len != 3'd0);
   assign grp       = grp_c;

   assign stat.held_count = held_count_ff;
   assign stat.held_lead  = held_lead_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
         held_lead_ff  <= 8'h00;
      end else if (accept) begin
         held_count_ff <= held_count_in;
         held_lead_ff  <= held_lead_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cont0_ff <= cont0_in;
         cont1_ff <= cont1_in;
      end
   end

endmodule

>>> sv/u8s_queue.sv
module u8s_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  u8s_pkg::group_type       in_grp,
   output logic                     out_valid,
   input  logic                     out_ready,
   output u8s_pkg::group_type       out_grp,
   output u8s_pkg::queue_stat_type  stat
);
   import u8s_pkg::*;

   group_type           slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff;
   logic [QUEUE_AW-1:0] rd_ptr_ff;
   logic [QUEUE_AW:0]   level_ff;
   logic                push;
   logic                pop;

   assign in_ready  = (level_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign out_valid = (level_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_grp   = slot_ff[rd_ptr_ff];
   assign stat.level = level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         end
         if (push && !pop) begin
            level_ff <= level_ff + (QUEUE_AW+1)'(1);
         end else if (pop && !push) begin
            level_ff <= level_ff - (QUEUE_AW+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_grp;
      end
   end

endmodule

>>> sv/u8s_back.sv
module u8s_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                grp_valid,
   output logic                grp_ready,
   input  u8s_pkg::group_type  grp,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [7:0]          out_byte,
   output logic                out_last
);
   import u8s_pkg::*;

   group_type  cur_ff;
   logic [1:0] idx_ff;
   logic       busy_ff;
   logic       fire;

   assign out_valid = busy_ff;
   assign out_byte  = cur_ff.data[idx_ff];
   assign out_last  = (({1'b0, idx_ff} + 3'd1) == cur_ff.len);
   assign fire      = busy_ff && out_ready;
   // take the next group as the current one leaves
   assign grp_ready = !busy_ff || (fire && out_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else if (grp_valid && grp_ready) begin
         busy_ff <= 1'b1;
         idx_ff  <= 2'd0;
      end else if (fire) begin
         if (out_last) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (grp_valid && grp_ready) begin
         cur_ff <= grp;
      end
   end

endmodule

>>> sv/utf8_sanitizer_core.sv
// with an idle back end, a byte that releases words is written into a queue slot as it is accepted;
//    the back end then loads the group into its current-group register and raises rsp_tvalid
// throughput: one byte per cycle in while the queue has room and one word per cycle out while groups
//    wait, the only limit being the rsp side, which drains one word a cycle from a four-group queue
// a byte may release up to four words; req stalls only while that queue is full
// reset (synchronous, active high) drops the held sequence, empties the queue and clears rsp_tvalid
module utf8_sanitizer_core (
   input  logic       clock,
   input  logic       reset,
   // input byte stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // end_of_string
   // sanitized byte stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // run_last
);
   import u8s_pkg::*;

   // front -> queue
   logic           f_grp_valid;
   logic           f_grp_ready;
   group_type      f_grp;
   front_stat_type f_stat;

   // queue -> back
   logic           q_grp_valid;
   logic           q_grp_ready;
   group_type      q_grp;
   queue_stat_type q_stat;

   // front: tracks the held sequence and builds the group of words each byte releases
   u8s_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_end    (req_tlast),
      .grp_valid (f_grp_valid),
      .grp_ready (f_grp_ready),
      .grp       (f_grp),
      .stat      (f_stat)
   );

   // short queue of groups so front and back stall independently
   u8s_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_grp_valid),
      .in_ready  (f_grp_ready),
      .in_grp    (f_grp),
      .out_valid (q_grp_valid),
      .out_ready (q_grp_ready),
      .out_grp   (q_grp),
      .stat      (q_stat)
   );

   // back: serializes each group, tlast on its final word
   u8s_back u_back (
      .clock     (clock),
      .reset     (reset),
      .grp_valid (q_grp_valid),
      .grp_ready (q_grp_ready),
      .grp       (q_grp),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

   // ---------------------------------------------------------------- checks

   // three bytes are held only behind a four-byte lead
   a_held_three_four_byte: assert property (@(posedge clock) disable iff (reset)
      (f_stat.held_count == 2'd3) |-> (f_stat.held_lead[7:3] == 5'b11110))
      else $error("three bytes held behind a lead that is not a four-byte lead");

   // a terminator or end flag leaves nothing held
   a_end_flushes: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tlast || (req_tdata == 8'h00)))
      |=> (f_stat.held_count == 2'd0))
      else $error("bytes still held after end of string");

   // a plain ascii byte with nothing held always reaches the queue or the back end
   a_ascii_forwarded: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (f_stat.held_count == 2'd0) && !req_tdata[7]
       && (req_tdata != 8'h00))
      |=> ((q_stat.level != '0) || rsp_tvalid))
      else $error("ascii byte dropped");

   // queue fill stays within its depth
   a_queue_level: assert property (@(posedge clock) disable iff (reset)
      q_stat.level <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue level beyond depth");

endmodule
